// ===== rtl/retp_pkg.sv =====
// Shared types, constants and codes of the row edge taper padder.
`timescale 1ns / 1ps

package retp_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int SUM_W      = 26;
    localparam int COUNT_W    = 13;
    localparam int PADLEN_W   = 6;
    localparam int STEP_W     = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int PROD_W     = 52;
    localparam int PAD_PROD_W = 42;

    localparam logic [COUNT_W-1:0]  MAX_ROW_LENGTH = 13'd4096;
    localparam logic [PADLEN_W-1:0] MAX_PAD        = 6'd50;
    localparam logic [STEP_W-1:0]   WEIGHT_ONE     = 17'd65536;

    // ceil(2^27 / 3): exact divide by three for magnitudes below 2^26
    localparam logic [SUM_W-1:0] RECIP3       = 26'd44739243;
    localparam int               RECIP3_SHIFT = 27;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [COUNT_W-1:0]  ROW_LENGTH_RST = 13'd512;
    localparam logic [PADLEN_W-1:0] PAD_LENGTH_RST = 6'd50;
    localparam logic [STEP_W-1:0]   PAD_STEP_RST   = 17'd1285;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_STEP   = 2'd2;

    // One queue entry: a row sample, plus the row sums when it closes the row.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
        logic signed [SUM_W-1:0]    start_sum;
        logic signed [SUM_W-1:0]    tail_sum;
        logic [1:0]                 fill;
    } t_entry;

    typedef struct packed {
        logic [PADLEN_W-1:0] pad_length;
        logic [STEP_W-1:0]   pad_step;
    } t_pad_cfg;

    typedef enum logic [2:0] {
        ST_PASS,
        ST_DIV,
        ST_PROD,
        ST_MEAN,
        ST_PAD_MUL,
        ST_PAD_OUT,
        ST_ZERO,
        ST_DONE
    } t_back_state;

endpackage

// ===== rtl/retp_front.sv =====
// Front end: row counting, start sum and tail window, builds queue entries.
`timescale 1ns / 1ps

module retp_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  logic signed [retp_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [retp_pkg::COUNT_W-1:0]        i_row_length,
    output retp_pkg::t_entry                    o_entry
);

    logic [retp_pkg::COUNT_W-1:0]         r_count, n_count;
    logic signed [retp_pkg::SUM_W-1:0]    r_start_sum, n_start_sum;
    logic signed [retp_pkg::SAMPLE_W-1:0] r_tw0, r_tw1;
    logic [retp_pkg::COUNT_W-1:0]         w_len;
    logic signed [retp_pkg::SUM_W-1:0]    w_s_ext;
    logic                                 w_last;

    always_comb begin
        if (i_row_length == '0) begin
            w_len = retp_pkg::COUNT_W'(1);
        end else if (i_row_length > retp_pkg::MAX_ROW_LENGTH) begin
            w_len = retp_pkg::MAX_ROW_LENGTH;
        end else begin
            w_len = i_row_length;
        end
    end

    assign w_s_ext = retp_pkg::SUM_W'(i_sample);
    assign n_count = (r_count == '1) ? r_count : r_count + retp_pkg::COUNT_W'(1);
    assign n_start_sum = (r_count < retp_pkg::COUNT_W'(3)) ? r_start_sum + w_s_ext
                                                           : r_start_sum;
    assign w_last = (n_count >= w_len);

    always_comb begin
        o_entry.sample    = i_sample;
        o_entry.last      = w_last;
        o_entry.start_sum = n_start_sum;
        o_entry.tail_sum  = w_s_ext + retp_pkg::SUM_W'(r_tw0) + retp_pkg::SUM_W'(r_tw1);
        o_entry.fill      = (n_count >= retp_pkg::COUNT_W'(3)) ? 2'd3 : n_count[1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_start_sum <= '0;
            r_tw0       <= '0;
            r_tw1       <= '0;
        end else if (i_accept) begin
            if (w_last) begin
                r_count     <= '0;
                r_start_sum <= '0;
                r_tw0       <= '0;
                r_tw1       <= '0;
            end else begin
                r_count     <= n_count;
                r_start_sum <= n_start_sum;
                r_tw0       <= i_sample;
                r_tw1       <= r_tw0;
            end
        end
    end

endmodule

// ===== rtl/retp_queue.sv =====
// Small FIFO of entries between the front end and the pad sequencer.
`timescale 1ns / 1ps

module retp_queue #(
    parameter int DEPTH = retp_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  retp_pkg::t_entry i_entry,
    output logic             o_full,
    input  logic             i_pop,
    output retp_pkg::t_entry o_head,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    retp_pkg::t_entry   r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               w_push, w_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/retp_back.sv =====
// Back end: passes samples out, then computes means and emits the pad run.
`timescale 1ns / 1ps

module retp_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  retp_pkg::t_entry                     i_head,
    input  logic                                 i_head_valid,
    output logic                                 o_pop,
    input  retp_pkg::t_pad_cfg                   i_pad_cfg,
    input  logic                                 i_out_pop,
    output logic                                 o_out_valid,
    output logic signed [retp_pkg::SAMPLE_W-1:0] o_out_sample,
    output logic                                 o_is_padding,
    output logic                                 o_row_done
);

    localparam int SW = retp_pkg::SAMPLE_W;
    localparam int UW = retp_pkg::SUM_W;
    localparam int PW = retp_pkg::PROD_W;
    localparam int AW = retp_pkg::PAD_PROD_W;
    localparam int KW = retp_pkg::PADLEN_W;
    localparam int TW = retp_pkg::STEP_W;

    retp_pkg::t_back_state r_state, n_state;

    logic signed [UW-1:0] r_ssum, n_ssum, r_tsum, n_tsum;
    logic [1:0]           r_fill, n_fill;
    logic [UW-1:0]        r_abs_s, n_abs_s, r_abs_t, n_abs_t;
    logic                 r_neg_s, n_neg_s, r_neg_t, n_neg_t;
    logic [PW-1:0]        r_prod_s, n_prod_s, r_prod_t, n_prod_t;
    logic signed [SW-1:0] r_stmean, n_stmean, r_endmean, n_endmean;
    logic [TW-1:0]        r_w, n_w, r_wc, n_wc;
    logic [KW-1:0]        r_k, n_k, r_npad, n_npad;
    logic signed [AW-1:0] r_pa, n_pa, r_pb, n_pb;

    logic                 r_o_valid, n_o_valid;
    logic signed [SW-1:0] r_o_sample, n_o_sample;
    logic                 r_o_pad, n_o_pad, r_o_done, n_o_done;

    logic                 w_slot_free;
    logic [UW-2:0]        w_q_s, w_q_t;
    logic signed [UW-1:0] w_mean_s, w_mean_t;
    logic [TW-1:0]        w_first_w, w_next_w;
    logic [TW:0]          w_w_sum;
    logic signed [AW-1:0] w_acc;
    logic signed [UW-1:0] w_pad_q;

    assign w_slot_free = !r_o_valid || i_out_pop;

    // truncating means for one, two or three terms
    always_comb begin
        unique case (r_fill)
            2'd3:    w_q_s = r_prod_s[retp_pkg::RECIP3_SHIFT +: UW-1];
            2'd2:    w_q_s = r_abs_s[UW-1:1];
            default: w_q_s = r_abs_s[UW-2:0];
        endcase
        unique case (r_fill)
            2'd3:    w_q_t = r_prod_t[retp_pkg::RECIP3_SHIFT +: UW-1];
            2'd2:    w_q_t = r_abs_t[UW-1:1];
            default: w_q_t = r_abs_t[UW-2:0];
        endcase
        w_mean_s = r_neg_s ? -$signed({1'b0, w_q_s}) : $signed({1'b0, w_q_s});
        w_mean_t = r_neg_t ? -$signed({1'b0, w_q_t}) : $signed({1'b0, w_q_t});
    end

    assign w_first_w = (i_pad_cfg.pad_step > retp_pkg::WEIGHT_ONE) ? retp_pkg::WEIGHT_ONE
                                                                   : i_pad_cfg.pad_step;
    assign w_w_sum   = {1'b0, r_w} + {1'b0, i_pad_cfg.pad_step};
    assign w_next_w  = (w_w_sum > {1'b0, retp_pkg::WEIGHT_ONE}) ? retp_pkg::WEIGHT_ONE
                                                                : w_w_sum[TW-1:0];

    // blend divided by 2^16, truncated toward zero
    assign w_acc   = r_pa + r_pb;
    assign w_pad_q = ((w_acc < 0) && (w_acc[15:0] != 16'd0))
                     ? w_acc[16 +: UW] + UW'(1) : w_acc[16 +: UW];

    always_comb begin
        n_state    = r_state;
        n_ssum     = r_ssum;
        n_tsum     = r_tsum;
        n_fill     = r_fill;
        n_abs_s    = r_abs_s;
        n_abs_t    = r_abs_t;
        n_neg_s    = r_neg_s;
        n_neg_t    = r_neg_t;
        n_stmean   = r_stmean;
        n_endmean  = r_endmean;
        n_w        = r_w;
        n_wc       = r_wc;
        n_k        = r_k;
        n_npad     = r_npad;
        n_pa       = r_pa;
        n_pb       = r_pb;
        n_o_valid  = (i_out_pop) ? 1'b0 : r_o_valid;
        n_o_sample = r_o_sample;
        n_o_pad    = r_o_pad;
        n_o_done   = r_o_done;
        o_pop      = 1'b0;

        unique case (r_state)
            retp_pkg::ST_PASS: begin
                if (i_head_valid && w_slot_free) begin
                    o_pop      = 1'b1;
                    n_o_valid  = 1'b1;
                    n_o_sample = i_head.sample;
                    n_o_pad    = 1'b0;
                    n_o_done   = 1'b0;
                    if (i_head.last) begin
                        n_ssum  = i_head.start_sum;
                        n_tsum  = i_head.tail_sum;
                        n_fill  = i_head.fill;
                        n_state = retp_pkg::ST_DIV;
                    end
                end
            end
            retp_pkg::ST_DIV: begin
                n_neg_s  = r_ssum[UW-1];
                n_neg_t  = r_tsum[UW-1];
                n_abs_s  = r_ssum[UW-1] ? UW'(-r_ssum) : UW'(r_ssum);
                n_abs_t  = r_tsum[UW-1] ? UW'(-r_tsum) : UW'(r_tsum);
                n_state  = retp_pkg::ST_PROD;
            end
            retp_pkg::ST_PROD: begin
                // magnitudes are registered; their products register now
                n_state  = retp_pkg::ST_MEAN;
            end
            retp_pkg::ST_MEAN: begin
                // products of the registered magnitudes are ready here
                n_stmean  = w_mean_s[SW-1:0];
                n_endmean = w_mean_t[SW-1:0];
                n_w       = w_first_w;
                n_wc      = retp_pkg::WEIGHT_ONE - w_first_w;
                n_k       = '0;
                n_npad    = (i_pad_cfg.pad_length > retp_pkg::MAX_PAD) ? retp_pkg::MAX_PAD
                                                                       : i_pad_cfg.pad_length;
                n_state   = (n_npad == '0) ? retp_pkg::ST_ZERO : retp_pkg::ST_PAD_MUL;
            end
            retp_pkg::ST_PAD_MUL: begin
                n_pa    = $signed({1'b0, r_w}) * r_stmean;
                n_pb    = $signed({1'b0, r_wc}) * r_endmean;
                n_state = retp_pkg::ST_PAD_OUT;
            end
            retp_pkg::ST_PAD_OUT: begin
                if (w_slot_free) begin
                    n_o_valid  = 1'b1;
                    n_o_sample = w_pad_q[SW-1:0];
                    n_o_pad    = 1'b1;
                    n_o_done   = 1'b0;
                    n_k        = r_k + KW'(1);
                    n_w        = w_next_w;
                    n_wc       = retp_pkg::WEIGHT_ONE - w_next_w;
                    n_state    = (n_k == r_npad) ? retp_pkg::ST_ZERO : retp_pkg::ST_PAD_MUL;
                end
            end
            retp_pkg::ST_ZERO: begin
                if (w_slot_free) begin
                    n_o_valid  = 1'b1;
                    n_o_sample = '0;
                    n_o_pad    = 1'b1;
                    n_o_done   = 1'b0;
                    n_state    = retp_pkg::ST_DONE;
                end
            end
            retp_pkg::ST_DONE: begin
                if (w_slot_free) begin
                    n_o_valid  = 1'b1;
                    n_o_sample = '0;
                    n_o_pad    = 1'b1;
                    n_o_done   = 1'b1;
                    n_state    = retp_pkg::ST_PASS;
                end
            end
            default: begin
                n_state = retp_pkg::ST_PASS;
            end
        endcase
    end

    // divide-by-three products, one register stage behind the magnitudes
    assign n_prod_s = r_abs_s * retp_pkg::RECIP3;
    assign n_prod_t = r_abs_t * retp_pkg::RECIP3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= retp_pkg::ST_PASS;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ssum     <= n_ssum;
        r_tsum     <= n_tsum;
        r_fill     <= n_fill;
        r_abs_s    <= n_abs_s;
        r_abs_t    <= n_abs_t;
        r_neg_s    <= n_neg_s;
        r_neg_t    <= n_neg_t;
        r_prod_s   <= n_prod_s;
        r_prod_t   <= n_prod_t;
        r_stmean   <= n_stmean;
        r_endmean  <= n_endmean;
        r_w        <= n_w;
        r_wc       <= n_wc;
        r_k        <= n_k;
        r_npad     <= n_npad;
        r_pa       <= n_pa;
        r_pb       <= n_pb;
        r_o_sample <= n_o_sample;
        r_o_pad    <= n_o_pad;
        r_o_done   <= n_o_done;
    end

    assign o_out_valid  = r_o_valid;
    assign o_out_sample = r_o_sample;
    assign o_is_padding = r_o_pad;
    assign o_row_done   = r_o_done;

endmodule

// ===== rtl/row_edge_taper_padder.sv =====
// Top level of the row edge taper padder: config registers, front, queue, back.
`timescale 1ns / 1ps

// Row edge taper padder.
// Input channel: i_sample with i_push / o_full; a transaction completes on an
// edge with i_push high and o_full low. Samples enter one per cycle unless o_full.
// Result channel: o_out_sample, o_is_padding, o_row_done with o_empty / i_pop; the
// oldest result sits on the ports while o_empty is low, taken when i_pop is high.
// Config channel: i_cfg_valid / o_cfg_ready (always ready), i_cfg_index picks
// row_length (0), pad_length (1) or pad_step (2); other indices are dropped.
// Write config only while the block is idle.
// A passed sample passes the queue and the output register. Throughput: one
// sample per cycle while the receiver keeps up and no mean or pad run is under way.
// After a row's last sample the back end forms the means (DIV, PROD, MEAN), then
// emits pad_length pad values, capped at 50, each via PAD_MUL and PAD_OUT, and
// two zeros, the second with row_done; the 4-entry queue takes input until it
// fills, then o_full holds the sender. If the receiver stalls, the output
// register holds its result and the queue fills behind it; nothing is dropped.
// Reset (synchronous, i_rst_n low) empties queue and output, clears the row
// state and restores row_length 512, pad_length 50, pad_step 1285.
module row_edge_taper_padder #(
    parameter int QUEUE_DEPTH = retp_pkg::QUEUE_DEPTH
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_push,
    output logic                                   o_full,
    input  logic signed [retp_pkg::SAMPLE_W-1:0]   i_sample,
    output logic                                   o_empty,
    input  logic                                   i_pop,
    output logic signed [retp_pkg::SAMPLE_W-1:0]   o_out_sample,
    output logic                                   o_is_padding,
    output logic                                   o_row_done,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [retp_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [retp_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    logic [retp_pkg::COUNT_W-1:0]  r_row_length;
    logic [retp_pkg::PADLEN_W-1:0] r_pad_length;
    logic [retp_pkg::STEP_W-1:0]   r_pad_step;

    retp_pkg::t_entry   w_entry, w_head;
    retp_pkg::t_pad_cfg w_pad_cfg;
    logic               w_accept, w_q_full, w_q_empty, w_q_pop, w_out_valid;

    assign o_cfg_ready = 1'b1;

    // register file; writes land at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length <= retp_pkg::ROW_LENGTH_RST;
            r_pad_length <= retp_pkg::PAD_LENGTH_RST;
            r_pad_step   <= retp_pkg::PAD_STEP_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                retp_pkg::REG_ROW_LENGTH: r_row_length <= i_cfg_data[retp_pkg::COUNT_W-1:0];
                retp_pkg::REG_PAD_LENGTH: r_pad_length <= i_cfg_data[retp_pkg::PADLEN_W-1:0];
                retp_pkg::REG_PAD_STEP:   r_pad_step   <= i_cfg_data[retp_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_pad_cfg.pad_length = r_pad_length;
    assign w_pad_cfg.pad_step   = r_pad_step;

    // an input transaction is exactly a queue push
    assign o_full   = w_q_full;
    assign w_accept = i_push && !w_q_full;

    retp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_sample     (i_sample),
        .i_row_length (r_row_length),
        .o_entry      (w_entry)
    );

    retp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_entry (w_entry),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_head  (w_head),
        .o_empty (w_q_empty)
    );

    retp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .i_head_valid (!w_q_empty),
        .o_pop        (w_q_pop),
        .i_pad_cfg    (w_pad_cfg),
        .i_out_pop    (i_pop),
        .o_out_valid  (w_out_valid),
        .o_out_sample (o_out_sample),
        .o_is_padding (o_is_padding),
        .o_row_done   (o_row_done)
    );

    assign o_empty = !w_out_valid;

    // back end never pops an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> !w_q_empty)
        else $error("queue popped while empty");

    // a row end marker only rides on a padding result
    a_done_is_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_row_done) |-> o_is_padding)
        else $error("row_done on a passthrough result");

    // a taken row_done result is never followed directly by another one
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && i_pop && o_row_done) |=> !(!o_empty && o_row_done))
        else $error("two row_done results in a row");

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the row edge taper padder.
`timescale 1ns / 1ps

module testbench;

    localparam int CLK_HALF_NS   = 2;
    localparam int RESET_CYCLES  = 4;
    localparam int SETTLE_CYCLES = 4;        // back end is idle once the last result pops
    localparam int DRAIN_TAIL    = 20;       // watch window for stray results at the end
    localparam int RANDOM_ITEMS  = 410;
    localparam int TIMEOUT_NS    = 8_000_000;

    // Index outside the register map; the block must drop the write.
    localparam logic [retp_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    // One result transaction as the block presents it.
    typedef struct packed {
        logic signed [retp_pkg::SAMPLE_W-1:0] value;
        logic                                 pad;
        logic                                 done;
    } t_taper_out;

    typedef enum logic {
        STEP_WRITE,
        STEP_SAMPLE
    } t_step_kind;

    // Directed table row: a register write or a sample. has_typed marks a
    // row-closing sample whose first pad-side value is written out by hand.
    typedef struct packed {
        t_step_kind                           kind;
        logic [retp_pkg::CFG_IDX_W-1:0]       idx;
        logic [retp_pkg::CFG_DATA_W-1:0]      data;
        logic signed [retp_pkg::SAMPLE_W-1:0] smp;
        logic                                 has_typed;
        logic signed [retp_pkg::SAMPLE_W-1:0] typed;
    } t_stim_step;

    // Receiver behavior, picked anew at random intervals.
    typedef enum logic [1:0] {
        RX_STREAM,
        RX_LIGHT,
        RX_HEAVY,
        RX_CRAWL
    } t_rx_mode;

    logic                                 i_clk;
    logic                                 i_rst_n     = 1'b0;
    logic                                 i_push      = 1'b0;
    logic                                 o_full;
    logic signed [retp_pkg::SAMPLE_W-1:0] i_sample    = '0;
    logic                                 o_empty;
    logic                                 i_pop       = 1'b0;
    logic signed [retp_pkg::SAMPLE_W-1:0] o_out_sample;
    logic                                 o_is_padding;
    logic                                 o_row_done;
    logic                                 i_cfg_valid = 1'b0;
    logic                                 o_cfg_ready;
    logic [retp_pkg::CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [retp_pkg::CFG_DATA_W-1:0]      i_cfg_data  = '0;

    row_edge_taper_padder i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_sample     (i_sample),
        .o_empty      (o_empty),
        .i_pop        (i_pop),
        .o_out_sample (o_out_sample),
        .o_is_padding (o_is_padding),
        .o_row_done   (o_row_done),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF_NS i_clk = ~i_clk;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #TIMEOUT_NS;
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor: register copies and row state, as seen after reset.
    // ------------------------------------------------------------------
    logic [retp_pkg::COUNT_W-1:0]  cfg_row_length = retp_pkg::ROW_LENGTH_RST;
    logic [retp_pkg::PADLEN_W-1:0] cfg_pad_length = retp_pkg::PAD_LENGTH_RST;
    logic [retp_pkg::STEP_W-1:0]   cfg_pad_step   = retp_pkg::PAD_STEP_RST;

    logic [retp_pkg::COUNT_W-1:0]  row_count      = '0;
    longint                        row_start_sum  = 0;
    longint                        tail_samples [3] = '{0, 0, 0};
    int unsigned                   tail_fill      = 0;
    int unsigned                   blend_weight   = 0;

    t_taper_out                    expected_outputs [$];
    int unsigned                   mismatch_count = 0;

    // Hand-typed value for the result right after the row's last passthrough.
    logic                                 typed_valid = 1'b0;
    logic signed [retp_pkg::SAMPLE_W-1:0] typed_value = '0;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Effective row length: zero acts as one, large values are capped.
    function automatic int unsigned eff_row_length();
        int unsigned len;
        len = (cfg_row_length == '0) ? 32'd1 : 32'(cfg_row_length);
        if (len > 32'(retp_pkg::MAX_ROW_LENGTH))
            len = 32'(retp_pkg::MAX_ROW_LENGTH);
        return len;
    endfunction

    // Expected results of one accepted sample: the sample itself, and when it
    // closes the row, the taper run and two zeros, the second with the row_done marker.
    task automatic predict_taper_outputs(input logic signed [retp_pkg::SAMPLE_W-1:0] smp);
        t_taper_out  outs [$];
        t_taper_out  item;
        int unsigned eff_len;
        int unsigned eff_pad;
        int unsigned n_start;
        int unsigned w;
        longint      start_mean;
        longint      end_mean;
        longint      tail_total;
        longint      quot;

        eff_len = eff_row_length();
        eff_pad = (cfg_pad_length > retp_pkg::MAX_PAD) ? 32'(retp_pkg::MAX_PAD)
                                                       : 32'(cfg_pad_length);

        if (row_count < 3)
            row_start_sum += longint'(smp);
        tail_samples[2] = tail_samples[1];
        tail_samples[1] = tail_samples[0];
        tail_samples[0] = longint'(smp);
        if (tail_fill < 3)
            tail_fill++;
        if (row_count != '1)
            row_count++;

        item = '{value: smp, pad: 1'b0, done: 1'b0};
        outs = {outs, item};

        if (32'(row_count) >= eff_len) begin
            n_start    = (row_count < 3) ? 32'(row_count) : 32'd3;
            start_mean = row_start_sum / longint'(n_start);
            tail_total = 0;
            for (int i = 0; i < tail_fill; i++)
                tail_total += tail_samples[i];
            end_mean = tail_total / longint'(tail_fill);

            // Weight of the start mean grows by pad_step per pad, capped at one.
            blend_weight = 0;
            for (int k = 0; k < eff_pad; k++) begin
                w = blend_weight + 32'(cfg_pad_step);
                if (w > 32'(retp_pkg::WEIGHT_ONE))
                    w = 32'(retp_pkg::WEIGHT_ONE);
                blend_weight = w;
                quot = (longint'(w) * start_mean
                        + longint'(32'(retp_pkg::WEIGHT_ONE) - w) * end_mean)
                       / longint'(retp_pkg::WEIGHT_ONE);
                item = '{value: quot[retp_pkg::SAMPLE_W-1:0], pad: 1'b1, done: 1'b0};
                outs = {outs, item};
            end
            item = '{value: '0, pad: 1'b1, done: 1'b0};
            outs = {outs, item};
            item = '{value: '0, pad: 1'b1, done: 1'b1};
            outs = {outs, item};

            if (typed_valid)
                outs[1].value = typed_value;

            row_count     = '0;
            row_start_sum = 0;
            tail_samples  = '{0, 0, 0};
            tail_fill     = 0;
            blend_weight  = 0;
        end

        foreach (outs[i])
            expected_outputs = {expected_outputs, outs[i]};
    endtask

    // ------------------------------------------------------------------
    // Monitor: everything is sampled at the rising edge. Result checks run
    // before new predictions, so their order is fixed.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_taper_out want;
        if (i_rst_n) begin
            if (i_pop && !o_empty) begin
                if (expected_outputs.size() == 0) begin
                    report_mismatch($sformatf("unexpected result value=%0d pad=%0b done=%0b",
                                              o_out_sample, o_is_padding, o_row_done));
                end else begin
                    want = expected_outputs.pop_front();
                    if (o_out_sample !== want.value)
                        report_mismatch($sformatf("out_sample %0d, want %0d",
                                                  o_out_sample, want.value));
                    if (o_is_padding !== want.pad)
                        report_mismatch($sformatf("is_padding %0b, want %0b",
                                                  o_is_padding, want.pad));
                    if (o_row_done !== want.done)
                        report_mismatch($sformatf("row_done %0b, want %0b",
                                                  o_row_done, want.done));
                end
            end

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    retp_pkg::REG_ROW_LENGTH:
                        cfg_row_length = i_cfg_data[retp_pkg::COUNT_W-1:0];
                    retp_pkg::REG_PAD_LENGTH:
                        cfg_pad_length = i_cfg_data[retp_pkg::PADLEN_W-1:0];
                    retp_pkg::REG_PAD_STEP:
                        cfg_pad_step   = i_cfg_data[retp_pkg::STEP_W-1:0];
                    default: ;      // unmapped index: dropped
                endcase
            end

            if (i_push && !o_full)
                predict_taper_outputs(i_sample);
        end
    end

    // ------------------------------------------------------------------
    // Receiver: pop pattern switches between streaming, light and heavy
    // random stalls, and a crawl that pops only when rx_left is a multiple of 20.
    // ------------------------------------------------------------------
    t_rx_mode    rx_mode = RX_STREAM;
    int unsigned rx_left = 0;

    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(4, 60);
        end
        rx_left--;
        case (rx_mode)
            RX_STREAM: i_pop <= 1'b1;
            RX_LIGHT:  i_pop <= ($urandom_range(0, 3) != 0);
            RX_HEAVY:  i_pop <= ($urandom_range(0, 3) == 0);
            default:   i_pop <= (rx_left % 20 == 0);
        endcase
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    int unsigned burst_left = 0;
    t_stim_step  directed_steps [$];

    function automatic void stage_write(input logic [retp_pkg::CFG_IDX_W-1:0] idx,
                                        input logic [retp_pkg::CFG_DATA_W-1:0] data);
        t_stim_step s;
        s = '0;
        s.kind = STEP_WRITE;
        s.idx  = idx;
        s.data = data;
        directed_steps = {directed_steps, s};
    endfunction

    function automatic void stage_sample(input logic signed [retp_pkg::SAMPLE_W-1:0] smp,
                                         input logic has_typed,
                                         input logic signed [retp_pkg::SAMPLE_W-1:0] typed);
        t_stim_step s;
        s = '0;
        s.kind      = STEP_SAMPLE;
        s.smp       = smp;
        s.has_typed = has_typed;
        s.typed     = typed;
        directed_steps = {directed_steps, s};
    endfunction

    // Stops the sender and waits until every expected result has popped.
    task automatic wait_idle();
        @(negedge i_clk);
        i_push <= 1'b0;
        while (expected_outputs.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [retp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [retp_pkg::CFG_DATA_W-1:0] data);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // One input transaction. Bursts of random length, random gaps between.
    task automatic send_sample(input logic signed [retp_pkg::SAMPLE_W-1:0] smp,
                               input logic has_typed,
                               input logic signed [retp_pkg::SAMPLE_W-1:0] typed);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                @(negedge i_clk);
                i_push <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_push      <= 1'b1;
        i_sample    <= smp;
        typed_valid  = has_typed;
        typed_value  = typed;
        do @(posedge i_clk); while (o_full);
    endtask

    function automatic logic signed [retp_pkg::SAMPLE_W-1:0] pick_sample();
        int unsigned r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return {1'b0, {(retp_pkg::SAMPLE_W-1){1'b1}}};
            1:       return {1'b1, {(retp_pkg::SAMPLE_W-1){1'b0}}};
            2, 3, 4: return retp_pkg::SAMPLE_W'(int'($urandom_range(0, 200)) - 100);
            default: return retp_pkg::SAMPLE_W'($urandom());
        endcase
    endfunction

    initial begin
        int unsigned sent;
        int unsigned row_n;
        int unsigned eff_len;
        int unsigned pad_n;
        int unsigned r;
        logic [retp_pkg::CFG_DATA_W-1:0] len_val;
        logic [retp_pkg::CFG_DATA_W-1:0] step_val;

        // Directed part. Typed values are the first result after the row's
        // last passthrough sample.
        // Zero row length acts as one; no taper, so the two trailing zeros follow.
        stage_write(retp_pkg::REG_ROW_LENGTH, '0);
        stage_write(retp_pkg::REG_PAD_LENGTH, '0);
        stage_write(retp_pkg::REG_PAD_STEP, '0);
        stage_sample(24'sd8388607, 1'b1, '0);
        // Pad length above the cap, step that saturates on the first pad:
        // every pad is the start mean.
        stage_write(retp_pkg::REG_PAD_LENGTH, 17'd63);
        stage_write(retp_pkg::REG_PAD_STEP, 17'h1FFFF);
        stage_sample(-24'sd8388608, 1'b1, -24'sd8388608);
        // Zero step: pure end mean, truncation toward zero on both signs.
        stage_write(retp_pkg::REG_ROW_LENGTH, 17'd3);
        stage_write(retp_pkg::REG_PAD_LENGTH, 17'd2);
        stage_write(retp_pkg::REG_PAD_STEP, '0);
        stage_sample(24'sd3, 1'b0, '0);
        stage_sample(-24'sd3, 1'b0, '0);
        stage_sample(24'sd7, 1'b1, 24'sd2);
        stage_sample(-24'sd1, 1'b0, '0);
        stage_sample(-24'sd1, 1'b0, '0);
        stage_sample(-24'sd2, 1'b1, -24'sd1);
        // Both extremes in one row, half weight.
        stage_write(retp_pkg::REG_ROW_LENGTH, 17'd2);
        stage_write(retp_pkg::REG_PAD_LENGTH, 17'd1);
        stage_write(retp_pkg::REG_PAD_STEP, 17'd32768);
        stage_sample(24'sd8388607, 1'b0, '0);
        stage_sample(-24'sd8388608, 1'b1, '0);
        // Distinct start and end means, quarter weight on the first pad.
        stage_write(retp_pkg::REG_ROW_LENGTH, 17'd5);
        stage_write(retp_pkg::REG_PAD_LENGTH, 17'd3);
        stage_write(retp_pkg::REG_PAD_STEP, 17'd16384);
        stage_sample(24'sd100, 1'b0, '0);
        stage_sample(24'sd200, 1'b0, '0);
        stage_sample(24'sd300, 1'b0, '0);
        stage_sample(-24'sd400, 1'b0, '0);
        stage_sample(-24'sd500, 1'b1, -24'sd100);
        // Unmapped index, then an oversize row length (capped) that is cut
        // short mid-row: the row closes on the next sample.
        stage_write(REG_UNMAPPED, 17'd5);
        stage_write(retp_pkg::REG_ROW_LENGTH, 17'h1FFFF);
        stage_sample(24'sd0, 1'b0, '0);
        stage_sample(24'sd1, 1'b0, '0);
        stage_sample(24'sd2, 1'b0, '0);
        stage_sample(24'sd4, 1'b0, '0);
        stage_write(retp_pkg::REG_ROW_LENGTH, 17'd2);
        stage_sample(24'sd8, 1'b1, 24'sd3);

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_steps[i]) begin
            if (directed_steps[i].kind == STEP_WRITE)
                write_reg(directed_steps[i].idx, directed_steps[i].data);
            else
                send_sample(directed_steps[i].smp, directed_steps[i].has_typed,
                            directed_steps[i].typed);
        end

        // Random rows. Each new setting is written with the block drained,
        // which also gives the full-drain pause on the sender side.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 2) != 0) begin
                r = $urandom_range(0, 19);
                if (r == 0)
                    len_val = '0;
                else if (r < 16)
                    len_val = retp_pkg::CFG_DATA_W'($urandom_range(1, 8));
                else if (r < 19)
                    len_val = retp_pkg::CFG_DATA_W'($urandom_range(9, 40));
                else
                    len_val = retp_pkg::CFG_DATA_W'($urandom_range(41, 120));
                write_reg(retp_pkg::REG_ROW_LENGTH, len_val);

                r = $urandom_range(0, 9);
                pad_n = (r == 0) ? $urandom_range(51, 63) : $urandom_range(0, 50);
                write_reg(retp_pkg::REG_PAD_LENGTH, retp_pkg::CFG_DATA_W'(pad_n));

                if (pad_n > 32'(retp_pkg::MAX_PAD))
                    pad_n = 32'(retp_pkg::MAX_PAD);
                r = $urandom_range(0, 9);
                if (r < 6)
                    step_val = retp_pkg::CFG_DATA_W'(retp_pkg::WEIGHT_ONE / (pad_n + 1));
                else if (r < 9)
                    step_val = retp_pkg::CFG_DATA_W'($urandom_range(0, 17'h1FFFF));
                else
                    step_val = retp_pkg::WEIGHT_ONE;
                write_reg(retp_pkg::REG_PAD_STEP, step_val);
            end

            eff_len = eff_row_length();
            // Mostly whole rows; now and then a partial one that the next
            // setting finishes.
            row_n = (eff_len > 1 && $urandom_range(0, 7) == 0)
                    ? $urandom_range(1, eff_len - 1) : eff_len;
            repeat (row_n) begin
                send_sample(pick_sample(), 1'b0, '0);
                sent++;
            end
        end

        wait_idle();
        repeat (DRAIN_TAIL) @(posedge i_clk);

        if (expected_outputs.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_outputs.size()));
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/retp_pkg.sv
rtl/retp_front.sv
rtl/retp_queue.sv
rtl/retp_back.sv
rtl/row_edge_taper_padder.sv
verif/testbench.sv
